[rtl/intlex_pkg.sv]
// Shared types, character codes and digit helpers for the integer literal lexer.
package intlex_pkg;

  localparam int VALUE_BITS = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOB   = 8'h62;
  localparam logic [7:0] CH_LOX   = 8'h78;
  localparam logic [7:0] CH_LOZ   = 8'h7A;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;
  localparam logic [1:0] RADIX_OCT = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       token_start;
    logic       end_of_input;
  } intlex_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
  } intlex_out_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } intlex_digit_t;

  // Digits 0-9 map to 0-9, letters of either case to 10-35.
  function automatic intlex_digit_t digit_of(input logic [7:0] c);
    intlex_digit_t d;
    d.ok  = 1'b1;
    d.val = 6'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.val = 6'(c - CH_ZERO);
    end else if (c >= CH_LOA && c <= CH_LOZ) begin
      d.val = 6'(c - CH_LOA) + 6'd10;
    end else if (c >= CH_UPA && c <= CH_UPZ) begin
      d.val = 6'(c - CH_UPA) + 6'd10;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [5:0] radix_base(input logic [1:0] r);
    logic [5:0] b;
    unique case (r)
      RADIX_DEC: b = 6'd10;
      RADIX_HEX: b = 6'd16;
      RADIX_BIN: b = 6'd2;
      default:   b = 6'd8;
    endcase
    return b;
  endfunction

endpackage

[rtl/intlex_core.sv]
// Token state and the per-character step logic of the lexer.
module intlex_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  intlex_pkg::intlex_in_t  item,
  output logic                 res_push,
  output intlex_pkg::intlex_out_t res_data
);
  import intlex_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_NEED   = 3'd3,
    PH_DIGITS = 3'd4,
    PH_PEND   = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic                    neg_r, neg_nxt;
  logic [1:0]              radix_r, radix_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;

  logic [7:0]              c;
  intlex_digit_t           dig;
  logic                    dig_in_base;
  logic [VALUE_BITS-1:0]   acc_scaled;
  logic [VALUE_BITS-1:0]   acc_signed_u;
  logic signed [VALUE_BITS-1:0] acc_signed;
  intlex_out_t             close_res;

  // Result of the first character after an optional sign.
  phase_t                  bf_phase;
  logic                    bf_fail;
  logic                    bf_digit;
  // Result of a start-marked character.
  phase_t                  st_phase;
  logic                    st_fail;
  logic                    st_neg;
  logic                    st_digit;

  assign c           = item.char_code;
  assign dig         = digit_of(c);
  assign dig_in_base = dig.ok && (dig.val < radix_base(radix_r));

  always_comb begin
    unique case (radix_r)
      RADIX_DEC: acc_scaled = (acc_r << 3) + (acc_r << 1);
      RADIX_HEX: acc_scaled = acc_r << 4;
      RADIX_BIN: acc_scaled = acc_r << 1;
      default:   acc_scaled = acc_r << 3;
    endcase
  end

  assign acc_signed_u = neg_r ? (VALUE_BITS'(0) - acc_r) : acc_r;
  assign acc_signed   = $signed(acc_signed_u);

  always_comb begin
    close_res.value = 32'sd0;
    close_res.ok    = 1'b0;
    if (phase_r == PH_ZERO) begin
      close_res.ok = 1'b1;
    end else if (phase_r == PH_DIGITS) begin
      close_res.value = 32'(acc_signed);
      close_res.ok    = 1'b1;
    end
  end

  always_comb begin
    bf_digit = 1'b0;
    bf_fail  = 1'b0;
    if (c == CH_ZERO) begin
      bf_phase = PH_ZERO;
    end else if (dig.ok && dig.val != 6'd0 && dig.val < 6'd10) begin
      bf_phase = PH_DIGITS;
      bf_digit = 1'b1;
    end else begin
      bf_phase = PH_IDLE;
      bf_fail  = 1'b1;
    end
    st_neg = (c == CH_MINUS);
    if (c == CH_PLUS || c == CH_MINUS) begin
      st_phase = PH_SIGNED;
      st_fail  = 1'b0;
      st_digit = 1'b0;
    end else begin
      st_phase = bf_phase;
      st_fail  = bf_fail;
      st_digit = bf_digit;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    radix_nxt      = radix_r;
    acc_nxt        = acc_r;
    res_push       = 1'b0;
    res_data.value = 32'sd0;
    res_data.ok    = 1'b0;

    if (phase_r == PH_PEND) begin
      // The held failure goes out before this character is looked at.
      res_push  = 1'b1;
      phase_nxt = PH_IDLE;
      if (!item.end_of_input && item.token_start) begin
        neg_nxt   = st_neg;
        radix_nxt = RADIX_DEC;
        acc_nxt   = st_digit ? VALUE_BITS'(dig.val) : '0;
        phase_nxt = st_fail ? PH_PEND : st_phase;
      end
    end else if (item.end_of_input) begin
      if (phase_r != PH_IDLE) begin
        res_push  = 1'b1;
        res_data  = close_res;
        phase_nxt = PH_IDLE;
      end
    end else if (phase_r == PH_IDLE) begin
      if (item.token_start) begin
        neg_nxt   = st_neg;
        radix_nxt = RADIX_DEC;
        acc_nxt   = st_digit ? VALUE_BITS'(dig.val) : '0;
        phase_nxt = st_phase;
        res_push  = st_fail;
      end
    end else if (item.token_start) begin
      // A start mark closes the open token and opens a new one.
      res_push  = 1'b1;
      res_data  = close_res;
      neg_nxt   = st_neg;
      radix_nxt = RADIX_DEC;
      acc_nxt   = st_digit ? VALUE_BITS'(dig.val) : '0;
      phase_nxt = st_fail ? PH_PEND : st_phase;
    end else begin
      unique case (phase_r)
        PH_SIGNED: begin
          phase_nxt = bf_phase;
          res_push  = bf_fail;
          if (bf_digit) begin
            radix_nxt = RADIX_DEC;
            acc_nxt   = VALUE_BITS'(dig.val);
          end
        end
        PH_ZERO: begin
          if (c == CH_LOX) begin
            radix_nxt = RADIX_HEX;
            phase_nxt = PH_NEED;
          end else if (c == CH_LOB) begin
            radix_nxt = RADIX_BIN;
            phase_nxt = PH_NEED;
          end else if (dig.ok && dig.val < 6'd8) begin
            radix_nxt = RADIX_OCT;
            acc_nxt   = VALUE_BITS'(dig.val);
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt   = PH_IDLE;
            res_push    = 1'b1;
            res_data.ok = 1'b1;
          end
        end
        PH_NEED: begin
          if (dig_in_base) begin
            acc_nxt   = VALUE_BITS'(dig.val);
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_IDLE;
            res_push  = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (c == CH_UNDER) begin
            phase_nxt = PH_DIGITS;
          end else if (dig_in_base) begin
            acc_nxt = acc_scaled + VALUE_BITS'(dig.val);
          end else begin
            phase_nxt = PH_IDLE;
            res_push  = 1'b1;
            res_data  = close_res;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (!step_en) begin
      phase_nxt = phase_r;
      neg_nxt   = neg_r;
      radix_nxt = radix_r;
      acc_nxt   = acc_r;
      res_push  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      radix_r <= RADIX_DEC;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

[rtl/intlex_outq.sv]
// Two-entry result queue that drives the result channel.
module intlex_outq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  intlex_pkg::intlex_out_t push_data,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_stall,
  output intlex_pkg::intlex_out_t out_data
);
  import intlex_pkg::*;

  logic [1:0]  cnt_r, cnt_nxt;
  intlex_out_t head_r, tail_r;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      head_r <= tail_r;
    end else if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      head_r <= push_data;
    end
    if (push && cnt_r == 2'd1 && !pop) begin
      tail_r <= push_data;
    end
  end

endmodule

[rtl/integer_literal_lexer_unit.sv]
// Top level of the integer literal lexer: input register, step logic, result queue.
//
//   channel | ports                         | payload
//   --------+-------------------------------+--------------------------------
//   input   | in_valid, in_stall, in_data   | char_code, token_start, end_of_input
//   result  | out_valid, out_stall, out_data| value, ok
//
// One character is taken per cycle while in_stall is low; the token state is
// updated from the input register, so the rate is one transaction per cycle
// whenever the result queue has room. A result is formed from the character in
// the input register, written into the result queue and taken from its head.
// Synchronous active-low reset returns the token state to idle and empties
// the register and the queue. in_stall rises only while a character waits in
// the input register and both result queue entries are occupied.
module integer_literal_lexer_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  intlex_pkg::intlex_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output intlex_pkg::intlex_out_t out_data
);
  import intlex_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  intlex_in_t  in_item_r;
  logic        q_full;
  logic        step_en;
  logic        res_push;
  intlex_out_t res_data;
  logic        in_take;

  assign in_stall     = in_valid_r && q_full;
  assign in_take      = in_valid && !in_stall;
  assign step_en      = in_valid_r && !q_full;
  assign in_valid_nxt = in_take || (in_valid_r && !step_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  intlex_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .item     (in_item_r),
    .res_push (res_push),
    .res_data (res_data)
  );

  intlex_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
